>>> hw/rtl/cbcs_pkg.sv
// Package for the conditional Bernoulli chain sampler.
// Types, codes and fixed widths shared by controller, datapath and top level.
// No dependencies.
package cbcs_pkg;

  localparam int FRAC = 16;
  localparam logic [FRAC:0] ONE_Q = 17'h10000;

  typedef enum logic [1:0] {
    KIND_WR_DEFAULT = 2'd0,
    KIND_WR_RULE    = 2'd1,
    KIND_SELECT     = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_ENTRY_COUNT = 1'd0,
    REG_HOLD_MODE   = 1'd1
  } reg_addr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [1:0]  rule_slot;
    logic        rule_enable;
    logic [15:0] cond_mask;
    logic [15:0] cond_values;
    logic [16:0] chance;
    logic [15:0] uniform_draw;
  } in_item_t;

  typedef struct packed {
    logic [15:0] on_set;
    logic [4:0]  on_total;
    logic        from_cache;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_START,
    ST_RULE_RD,
    ST_RULE_EV,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic do_write;
    logic start;
    logic rule_rd;
    logic rule_ev;
    logic div_init;
    logic div_step;
    logic div_done;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic chain_end;
    logic last_slot;
    logic div_skip;
    logic div_last;
    logic cache_hit;
  } stat_t;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) n = n + 5'(v[i]);
    return n;
  endfunction

endpackage

>>> hw/rtl/cbcs_ctrl.sv
// Controller state machine of the sampler.
// Depends on cbcs_pkg; drives commands into cbcs_dp.
module cbcs_ctrl import cbcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic [1:0] in_kind,
  input  logic     out_busy,
  input  stat_t    stat,
  output cmd_t     cmd,
  output logic     idle
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_WR_DEFAULT || in_kind == KIND_WR_RULE) state_next = ST_WRITE;
          else if (in_kind == KIND_SELECT) state_next = ST_START;
        end
      end
      ST_WRITE:    state_next = ST_IDLE;
      ST_START:    state_next = stat.cache_hit ? ST_OUT
                              : (stat.chain_end ? ST_FINISH : ST_RULE_RD);
      ST_RULE_RD:  state_next = ST_RULE_EV;
      ST_RULE_EV:  state_next = stat.last_slot ? ST_DIV_INIT : ST_RULE_RD;
      ST_DIV_INIT: state_next = stat.div_skip ? ST_DIV_DONE : ST_DIV_RUN;
      ST_DIV_RUN:  state_next = stat.div_last ? ST_DIV_DONE : ST_DIV_RUN;
      ST_DIV_DONE: state_next = stat.chain_end ? ST_FINISH : ST_RULE_RD;
      ST_FINISH:   state_next = ST_OUT;
      ST_OUT:      state_next = out_busy ? ST_OUT : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    case (state)
      ST_IDLE:     idle = 1'b1;
      ST_WRITE:    cmd.do_write = 1'b1;
      ST_START:    cmd.start = 1'b1;
      ST_RULE_RD:  cmd.rule_rd = 1'b1;
      ST_RULE_EV:  cmd.rule_ev = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_DIV_DONE: cmd.div_done = 1'b1;
      ST_FINISH:   cmd.finish = 1'b1;
      ST_OUT:      cmd.load_out = !out_busy;
      default:     idle = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/cbcs_dp.sv
// Datapath of the sampler: tables, rule scan, serial divider, cache.
// Depends on cbcs_pkg; commanded by cbcs_ctrl.
module cbcs_dp import cbcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  in_item_t in_item,
  input  logic [4:0] entry_count,
  input  logic     hold_mode,
  input  cmd_t     cmd,
  output stat_t    stat,
  output out_item_t res
);

  localparam int NRULE = 64;

  in_item_t item;
  logic [16:0] default_mem [16];
  logic [48:0] rule_mem [NRULE];
  logic [NRULE-1:0] rule_valid;
  logic        cache_valid;
  logic [15:0] cached_set;

  logic [3:0]  ent;
  logic [1:0]  slot;
  logic [4:0]  n_eff;
  logic [15:0] rem;
  logic [15:0] set;
  logic [16:0] prob;
  logic [5:0]  best;
  logic        rv;
  logic [48:0] rword;
  logic [16:0] dflt;
  logic        hit;
  logic        on_bit;
  logic [16:0] divisor;
  logic [32:0] prem;
  logic [15:0] quot;
  logic [4:0]  dcnt;

  logic [16:0] chance_sat;
  logic [5:0]  wr_addr;
  logic [5:0]  rd_addr;
  logic [15:0] rmask, rvals;
  logic [4:0]  rbits;
  logic [33:0] trial;

  assign chance_sat = (item.chance > ONE_Q) ? ONE_Q : item.chance;
  assign wr_addr = {item.entry_index, item.rule_slot};
  assign rd_addr = {ent, slot};
  assign rmask = rword[48:33];
  assign rvals = rword[32:17];
  assign rbits = popcount16(rmask);
  assign trial = {prem, 1'b0} - {1'b0, divisor, 16'd0};

  // n_eff is only loaded at the start edge, so test the register directly there
  assign stat.chain_end = cmd.start ? (entry_count == 5'd0)
                                    : ({1'b0, ent} == n_eff - 5'd1);
  assign stat.last_slot = (slot == 2'd3);
  assign stat.div_skip  = ({1'b0, rem} >= prob) && (prob == ONE_Q);
  assign stat.div_last  = (dcnt == 5'd15);
  assign stat.cache_hit = hold_mode && cache_valid;

  always_ff @(posedge clk) begin
    if (in_fire) item <= in_item;
    rword <= rule_mem[rd_addr];
    rv    <= rule_valid[rd_addr];
    dflt  <= default_mem[ent];
    if (cmd.do_write) begin
      if (item.kind == KIND_WR_DEFAULT) default_mem[item.entry_index] <= chance_sat;
      else rule_mem[wr_addr] <= {item.cond_mask, item.cond_values, chance_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_valid  <= '0;
      cache_valid <= 1'b0;
      cached_set  <= '0;
    end else begin
      if (cmd.do_write) begin
        cache_valid <= 1'b0;
        if (item.kind == KIND_WR_RULE) rule_valid[wr_addr] <= item.rule_enable;
      end
      if (cmd.finish && hold_mode) begin
        cache_valid <= 1'b1;
        cached_set  <= set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_eff <= (entry_count > 5'd16) ? 5'd16 : entry_count;
      rem   <= item.uniform_draw;
      set   <= '0;
      ent   <= '0;
      slot  <= '0;
      hit   <= hold_mode && cache_valid;
      best  <= 6'h3f;
    end
    if (cmd.rule_ev) begin
      if (slot == 2'd0) prob <= dflt;
      if (rv && ((set & rmask) == (rvals & rmask)) &&
          (best == 6'h3f || {1'b0, rbits} > best)) begin
        best <= {1'b0, rbits};
        prob <= rword[16:0];
      end
      slot <= slot + 2'd1;
    end
    if (cmd.div_init) begin
      on_bit <= ({1'b0, rem} < prob);
      dcnt   <= '0;
      if ({1'b0, rem} < prob) begin
        set[ent] <= 1'b1;
        divisor  <= prob;
        prem     <= {1'b0, rem, 16'd0};
      end else begin
        divisor  <= ONE_Q - prob;
        prem     <= {1'b0, rem - prob[15:0], 16'd0};
      end
    end
    if (cmd.div_step) begin
      // restoring division, remainder held aligned with divisor<<16
      if (!trial[33]) begin
        prem <= trial[32:0];
        quot <= {quot[14:0], 1'b1};
      end else begin
        prem <= {prem[31:0], 1'b0};
        quot <= {quot[14:0], 1'b0};
      end
      dcnt <= dcnt + 5'd1;
    end
    if (cmd.div_done) begin
      if (!stat.div_skip) rem <= quot;
      ent  <= ent + 4'd1;
      slot <= '0;
      best <= 6'h3f;
    end
    if (cmd.load_out) begin
      res.on_set     <= hit ? cached_set : set;
      res.on_total   <= popcount16(hit ? cached_set : set);
      res.from_cache <= hit;
    end
  end

endmodule

>>> hw/rtl/conditional_bernoulli_chain_sampler_top.sv
// Top level of the conditional Bernoulli chain sampler.
// Depends on cbcs_pkg, cbcs_ctrl and cbcs_dp.
//
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    in_item_t
// out       out  out_valid/out_ready  out_item_t
// apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// A select runs four registered rule reads plus a 16-step serial divider per
// entry; a cached select goes from start straight to the result register.
// rst is synchronous; it clears rule valid bits, cache, registers, FSM.
// The result register holds until taken; in_ready drops while busy.
module conditional_bernoulli_chain_sampler_top import cbcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic [4:0] entry_count;
  logic       hold_mode;
  cmd_t       cmd;
  stat_t      stat;
  logic       idle;
  logic       in_fire;
  out_item_t  res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      hold_mode   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ENTRY_COUNT) entry_count <= pwdata[4:0];
      else hold_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {27'd0, entry_count} : {31'd0, hold_mode};

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  // result register: load when free, clear on take
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  assign out_item = res;

  cbcs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_kind(in_item.kind),
    .out_busy(out_valid && !out_ready), .stat, .cmd, .idle
  );

  cbcs_dp u_dp (
    .clk, .rst, .in_fire, .in_item, .entry_count, .hold_mode, .cmd, .stat, .res
  );

endmodule

>>> hw/rtl/cbcs_checker.sv
// Port-level checker for the sampler, bound to the top level.
// Depends on cbcs_pkg.
module cbcs_checker import cbcs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item,
  input logic      pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.on_total == $countones(out_item.on_set))
    else $error("on_total mismatch");

  // unused kind is dropped in place, so only real transactions make it busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.kind != KIND_NONE |=> !in_ready)
    else $error("accepted while busy");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind conditional_bernoulli_chain_sampler_top cbcs_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item, .pready
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for conditional_bernoulli_chain_sampler_top: random and directed table writes
// and selects, checked against a built-in fixed-point predictor. Depends on cbcs_pkg.
module testbench;
  import cbcs_pkg::*;

  localparam int N_ENTRY = 16;
  localparam int N_SLOT = 4;
  localparam longint ONE = 64'd65536;
  localparam int DRAIN_CYCLES = 600;   // longer than a full 16-entry select
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  conditional_bernoulli_chain_sampler_top dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [16:0] dflt_chance [N_ENTRY];
  logic        rl_valid [N_ENTRY*N_SLOT];
  logic [15:0] rl_mask [N_ENTRY*N_SLOT];
  logic [15:0] rl_values [N_ENTRY*N_SLOT];
  logic [16:0] rl_chance [N_ENTRY*N_SLOT];
  logic        held_valid;
  logic [15:0] held_set;
  logic [4:0]  cfg_entries;
  logic        cfg_hold;

  in_item_t  pending_items[$];
  out_item_t expected_samples[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold_req = 0;
  int hold_left = 0;
  int cycles = 0;

  function automatic logic [16:0] clamp_chance(logic [16:0] c);
    return (c > ONE) ? 17'(ONE) : c;
  endfunction

  // Walk the chain with one draw; remainder rescaled after every decision.
  function automatic logic [15:0] predict_selection(logic [15:0] draw);
    longint unsigned r, p;
    logic [15:0] on_bits;
    int n, best, bits, k;
    r = draw;
    on_bits = '0;
    n = (cfg_entries > N_ENTRY) ? N_ENTRY : cfg_entries;
    for (int e = 0; e < n; e++) begin
      p = dflt_chance[e];
      best = -1;
      for (int s = 0; s < N_SLOT; s++) begin
        k = e * N_SLOT + s;
        if (rl_valid[k] && ((on_bits & rl_mask[k]) == (rl_values[k] & rl_mask[k]))) begin
          bits = $countones(rl_mask[k]);
          if (bits > best) begin
            best = bits;
            p = rl_chance[k];
          end
        end
      end
      if (r < p) begin
        on_bits[e] = 1'b1;
        r = (r << 16) / p;
      end else if (p != ONE) begin
        r = ((r - p) << 16) / (ONE - p);
      end
      if (r >= ONE) r = ONE - 1;
    end
    return on_bits;
  endfunction

  task automatic apply_item(in_item_t it);
    out_item_t res;
    int k;
    case (it.kind)
      KIND_WR_DEFAULT: begin
        dflt_chance[it.entry_index] = clamp_chance(it.chance);
        held_valid = 1'b0;
      end
      KIND_WR_RULE: begin
        k = it.entry_index * N_SLOT + it.rule_slot;
        rl_valid[k] = it.rule_enable;
        rl_mask[k] = it.cond_mask;
        rl_values[k] = it.cond_values;
        rl_chance[k] = clamp_chance(it.chance);
        held_valid = 1'b0;
      end
      KIND_SELECT: begin
        res.from_cache = 1'b0;
        if (cfg_hold && held_valid) begin
          res.on_set = held_set;
          res.from_cache = 1'b1;
        end else begin
          res.on_set = predict_selection(it.uniform_draw);
          if (cfg_hold) begin
            held_set = res.on_set;
            held_valid = 1'b1;
          end
        end
        res.on_total = 5'($countones(res.on_set));
        expected_samples = {expected_samples, res};
      end
      default: ;  // unused kind: no effect
    endcase
  endtask

  // Driver: records each accepted transaction, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_item(in_item);
      if (in_valid && !in_ready) begin
        // hold the offer
      end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls, one long hold-off on request, field checks.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result on_set=%h", out_item.on_set);
          errors++;
        end else begin
          out_item_t want;
          want = expected_samples.pop_front();
          if (out_item.on_set !== want.on_set) begin
            $error("on_set expected %h got %h", want.on_set, out_item.on_set);
            errors++;
          end
          if (out_item.on_total !== want.on_total) begin
            $error("on_total expected %0d got %0d", want.on_total, out_item.on_total);
            errors++;
          end
          if (out_item.from_cache !== want.from_cache) begin
            $error("from_cache expected %0d got %0d", want.from_cache, out_item.from_cache);
            errors++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[conditional_bernoulli_chain_sampler_top] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
  endtask

  // APB write: setup, access; register taken at the access edge.
  task automatic reg_write(reg_addr_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ENTRY_COUNT) cfg_entries = val[4:0];
    else cfg_hold = val[0];
  endtask

  task automatic configure(logic [4:0] entries, logic hold);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(REG_ENTRY_COUNT, 32'(entries));
    reg_write(REG_HOLD_MODE, 32'(hold));
  endtask

  function automatic logic [16:0] rand_chance();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'h10000 + 17'($urandom_range(65535, 1));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel, e;
    it = '0;
    it.uniform_draw = 16'($urandom);
    if ($urandom_range(9) == 0) it.uniform_draw = $urandom_range(1) ? 16'hFFFF : 16'h0;
    it.entry_index = 4'($urandom);
    it.rule_slot = 2'($urandom);
    it.rule_enable = ($urandom_range(3) != 0);
    e = it.entry_index;
    // masks mostly over earlier entries, sometimes anything
    if (e > 0 && $urandom_range(3) != 0)
      it.cond_mask = 16'($urandom) & 16'((32'd1 << e) - 1);
    else
      it.cond_mask = 16'($urandom);
    if ($urandom_range(5) == 0) it.cond_mask = '0;
    it.cond_values = 16'($urandom);
    it.chance = rand_chance();
    sel = $urandom_range(99);
    if (sel < 45) it.kind = KIND_SELECT;
    else if (sel < 72) it.kind = KIND_WR_RULE;
    else if (sel < 95) it.kind = KIND_WR_DEFAULT;
    else it.kind = KIND_NONE;
    return it;
  endfunction

  function automatic in_item_t mk(kind_t k, int e, int s, int en, int m,
                                  int v, int c, int d);
    in_item_t it;
    it.kind = k;
    it.entry_index = 4'(e);
    it.rule_slot = 2'(s);
    it.rule_enable = 1'(en);
    it.cond_mask = 16'(m);
    it.cond_values = 16'(v);
    it.chance = 17'(c);
    it.uniform_draw = 16'(d);
    return it;
  endfunction

  initial begin
    logic [4:0] cnt_list [8] = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd16, 5'd1, 5'd12, 5'd16};
    int idle_s [4] = '{0, 69, 0, 10};
    int idle_r [4] = '{0, 0, 69, 10};
    for (int i = 0; i < N_ENTRY*N_SLOT; i++) rl_valid[i] = 1'b0;
    for (int i = 0; i < N_ENTRY; i++) dflt_chance[i] = '0;
    held_valid = 1'b0;
    held_set = '0;
    cfg_entries = '0;
    cfg_hold = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: every default written before any select reaches it
    configure(5'd16, 1'b0);
    for (int i = 0; i < N_ENTRY; i++)
      pending_items = {pending_items, mk(KIND_WR_DEFAULT, i, 0, 0, 0, 0,
        (i == 0) ? 17'd0 : (i == 1) ? 17'h10000 : (i == 2) ? 17'h1FFFF : 17'h8000, 0)};
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'h0000)};
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'hFFFF)};
    // empty-mask rule, rule on self and later entries, tie on specificity
    pending_items = {pending_items, mk(KIND_WR_RULE, 3, 0, 1, 16'h0000, 16'h0, 17'h10000, 0)};
    pending_items = {pending_items, mk(KIND_WR_RULE, 4, 1, 1, 16'hFFF0, 16'h0000, 17'h0, 0)};
    pending_items = {pending_items, mk(KIND_WR_RULE, 5, 2, 1, 16'h0002, 16'h0002, 17'hFFFF, 0)};
    pending_items = {pending_items, mk(KIND_WR_RULE, 5, 3, 1, 16'h0004, 16'h0004, 17'h1, 0)};
    pending_items = {pending_items,
                     mk(KIND_NONE, 15, 3, 1, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 16'hFFFF)};
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'h7FFF)};
    // hold mode: cache, repeat, unused kind keeps cache, write clears it
    configure(5'd16, 1'b1);
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'h1234)};
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'hFEDC)};
    pending_items = {pending_items, mk(KIND_NONE, 0, 0, 0, 0, 0, 0, 16'h0)};
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'h0)};
    pending_items = {pending_items, mk(KIND_WR_DEFAULT, 7, 0, 0, 0, 0, 17'h4000, 0)};
    pending_items = {pending_items, mk(KIND_SELECT, 0, 0, 0, 0, 0, 0, 16'hA5A5)};
    configure(5'd16, 1'b0);  // leaves cache in place but unused

    // random phases over idle settings and register settings
    for (int ph = 0; ph < 8; ph++) begin
      configure(cnt_list[ph], ph[0]);
      send_idle_pct = idle_s[ph / 2];
      recv_stall_pct = idle_r[ph / 2];
      if (ph == 0) long_hold_req = 1;  // receiver holds off, sender keeps offering
      for (int chunk = 0; chunk < 3; chunk++) begin
        for (int i = 0; i < 30; i++) pending_items = {pending_items, rand_item()};
        wait_idle();  // sender pauses until every result is back
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("[conditional_bernoulli_chain_sampler_top] OK");
    else $display("[conditional_bernoulli_chain_sampler_top] ERROR");
    $finish;
  end

endmodule
